// ===== src/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types and codes of the s-expression token scanner: byte classes,
// scan modes, token kinds and the item and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package lts_pkg;

   // byte classes, worked out by the front part
   localparam logic [3:0] CLS_NUL     = 4'd0;
   localparam logic [3:0] CLS_LPAREN  = 4'd1;
   localparam logic [3:0] CLS_RPAREN  = 4'd2;
   localparam logic [3:0] CLS_UPPER   = 4'd3;
   localparam logic [3:0] CLS_DIGIT   = 4'd4;
   localparam logic [3:0] CLS_QUOTE   = 4'd5;
   localparam logic [3:0] CLS_SEMI    = 4'd6;
   localparam logic [3:0] CLS_SPACE   = 4'd7;
   localparam logic [3:0] CLS_NEWLINE = 4'd8;
   localparam logic [3:0] CLS_OTHER   = 4'd9;

   // scan modes
   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_SYMBOL  = 3'd1;
   localparam logic [2:0] MODE_NUMBER  = 3'd2;
   localparam logic [2:0] MODE_STRING  = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;
   localparam logic [2:0] MODE_ERROR   = 3'd5;

   // token kinds
   localparam logic [3:0] KIND_LPAREN  = 4'd0;
   localparam logic [3:0] KIND_RPAREN  = 4'd1;
   localparam logic [3:0] KIND_SYMBYTE = 4'd2;
   localparam logic [3:0] KIND_SYMEND  = 4'd3;
   localparam logic [3:0] KIND_NUMBER  = 4'd4;
   localparam logic [3:0] KIND_STRBYTE = 4'd5;
   localparam logic [3:0] KIND_STREND  = 4'd6;
   localparam logic [3:0] KIND_END     = 4'd7;
   localparam logic [3:0] KIND_ERROR   = 4'd8;

   localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

   // result queue depth, a power of two
   localparam int RSP_DEPTH = 4;

   typedef struct packed {
      logic [7:0] char_code;
      logic [3:0] cls;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } front_type;

   typedef struct packed {
      logic [3:0]  kind;
      logic [62:0] number_value;
      logic [7:0]  text_byte;
      logic [15:0] text_length;
      logic        last;
   } result_type;

   // push1 only ever comes with push0
   typedef struct packed {
      logic       push0;
      logic       push1;
      result_type r0;
      result_type r1;
   } rsp_write_type;

endpackage

`default_nettype wire

// ===== src/lts_front.sv =====
// ----------------------------------------------------------------------------
// lts_front
// Accepts source bytes, classifies each one and holds it in a two-entry
// queue until the scan engine takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [7:0]         req_char_code,
   input  wire logic               req_push,
   output logic                    req_full,
   output lts_pkg::front_type      front,
   input  wire logic               take
);
   import lts_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [3:0] cls;
   logic       accept;
   logic       pop;

   always_comb begin
      unique case (req_char_code) inside
         8'h00:             cls = CLS_NUL;
         8'h28:             cls = CLS_LPAREN;
         8'h29:             cls = CLS_RPAREN;
         [8'h41:8'h5A]:     cls = CLS_UPPER;
         [8'h30:8'h39]:     cls = CLS_DIGIT;
         8'h22:             cls = CLS_QUOTE;
         8'h3B:             cls = CLS_SEMI;
         8'h20, 8'h0D, 8'h09: cls = CLS_SPACE;
         8'h0A:             cls = CLS_NEWLINE;
         default:           cls = CLS_OTHER;
      endcase
   end

   assign req_full    = (cnt_ff == 2'd2);
   assign accept      = req_push && !req_full;
   assign front.valid = (cnt_ff != 2'd0);
   assign front.item  = q_ff[rd_ptr_ff];
   assign pop         = take && front.valid;

   assign wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
   assign cnt_in    = cnt_ff + 2'(accept) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= '{char_code: req_char_code, cls: cls};
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("front queue count out of range");

   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |->
         cnt_ff == $past(cnt_ff) + 2'($past(accept)) - 2'($past(pop)))
      else $error("front queue count does not follow push and take");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("front queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== src/lts_back.sv =====
// ----------------------------------------------------------------------------
// lts_back
// Scan engine: keeps the scan mode, number accumulator and text length and
// turns each classified byte into zero, one or two tokens.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lts_pkg::front_type  front,
   output logic                     take,
   input  wire logic                room,
   output lts_pkg::rsp_write_type   wr
);
   import lts_pkg::*;

   logic [2:0]  mode_ff, mode_in;
   logic [62:0] acc_ff, acc_in;
   logic [15:0] len_ff, len_in;

   logic [7:0]  c;
   logic [3:0]  cls;
   logic [15:0] len_inc;
   logic [66:0] acc_x10;
   logic [62:0] acc_next_digit;
   logic        run_idle;
   logic        v0, v1, iv;
   result_type  r0, r1, ir;

   assign take = front.valid && room;
   assign c    = front.item.char_code;
   assign cls  = front.item.cls;

   assign len_inc = (len_ff != LENGTH_MAX) ? len_ff + 16'd1 : len_ff;

   // times ten by shift and add, saturate when anything lands above bit 62
   assign acc_x10 = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {63'd0, c[3:0]};
   assign acc_next_digit = (acc_x10[66:63] != 4'd0) ? {63{1'b1}} : acc_x10[62:0];

   always_comb begin
      mode_in  = mode_ff;
      acc_in   = acc_ff;
      len_in   = len_ff;
      run_idle = 1'b0;
      v0       = 1'b0;
      v1       = 1'b0;
      iv       = 1'b0;
      r0       = '0;
      r1       = '0;
      ir       = '0;

      unique case (mode_ff)
         MODE_SYMBOL: begin
            if (cls == CLS_UPPER || cls == CLS_DIGIT) begin
               len_in       = len_inc;
               v0           = 1'b1;
               r0.kind      = KIND_SYMBYTE;
               r0.text_byte = c;
            end else begin
               v0             = 1'b1;
               r0.kind        = KIND_SYMEND;
               r0.text_length = len_ff;
               len_in         = 16'd0;
               run_idle       = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (cls == CLS_DIGIT) begin
               acc_in = acc_next_digit;
            end else begin
               v0              = 1'b1;
               r0.kind         = KIND_NUMBER;
               r0.number_value = acc_ff;
               acc_in          = 63'd0;
               run_idle        = 1'b1;
            end
         end
         MODE_STRING: begin
            if (cls == CLS_QUOTE) begin
               v0             = 1'b1;
               r0.kind        = KIND_STREND;
               r0.text_length = len_ff;
               len_in         = 16'd0;
               mode_in        = MODE_IDLE;
            end else if (cls == CLS_NUL) begin
               v0       = 1'b1;
               r0.kind  = KIND_ERROR;
               run_idle = 1'b1;
            end else begin
               len_in       = len_inc;
               v0           = 1'b1;
               r0.kind      = KIND_STRBYTE;
               r0.text_byte = c;
            end
         end
         MODE_COMMENT: begin
            if (cls == CLS_NEWLINE) begin
               mode_in = MODE_IDLE;
            end else if (cls == CLS_NUL) begin
               run_idle = 1'b1;
            end
         end
         MODE_ERROR: begin
            if (cls == CLS_NUL) begin
               run_idle = 1'b1;
            end
         end
         default: begin
            run_idle = 1'b1;
         end
      endcase

      // the byte as seen from idle, after any token it closed
      if (run_idle) begin
         mode_in = MODE_IDLE;
         unique case (cls)
            CLS_NUL: begin
               acc_in  = 63'd0;
               len_in  = 16'd0;
               iv      = 1'b1;
               ir.kind = KIND_END;
            end
            CLS_LPAREN: begin
               iv      = 1'b1;
               ir.kind = KIND_LPAREN;
            end
            CLS_RPAREN: begin
               iv      = 1'b1;
               ir.kind = KIND_RPAREN;
            end
            CLS_UPPER: begin
               mode_in      = MODE_SYMBOL;
               len_in       = 16'd1;
               iv           = 1'b1;
               ir.kind      = KIND_SYMBYTE;
               ir.text_byte = c;
            end
            CLS_DIGIT: begin
               mode_in = MODE_NUMBER;
               acc_in  = {59'd0, c[3:0]};
            end
            CLS_QUOTE: begin
               mode_in = MODE_STRING;
               len_in  = 16'd0;
            end
            CLS_SEMI: begin
               mode_in = MODE_COMMENT;
            end
            CLS_SPACE, CLS_NEWLINE: begin
               mode_in = MODE_IDLE;
            end
            default: begin
               mode_in = MODE_ERROR;
               iv      = 1'b1;
               ir.kind = KIND_ERROR;
            end
         endcase
         if (v0) begin
            v1 = iv;
            r1 = ir;
         end else begin
            v0 = iv;
            r0 = ir;
         end
      end

      // flag the final token of this byte
      if (v1) begin
         r1.last = 1'b1;
      end else begin
         r0.last = v0;
      end
   end

   assign wr.push0 = take && v0;
   assign wr.push1 = take && v1;
   assign wr.r0    = r0;
   assign wr.r1    = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         acc_ff  <= 63'd0;
         len_ff  <= 16'd0;
      end else if (take) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         len_ff  <= len_in;
      end
   end

   a_acc_only_in_number: assert property (@(posedge clock) disable iff (reset)
      mode_ff != MODE_NUMBER |-> acc_ff == 63'd0)
      else $error("accumulator holds a value outside number mode");

   a_len_only_in_text: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != MODE_SYMBOL && mode_ff != MODE_STRING) |-> len_ff == 16'd0)
      else $error("length count holds a value outside symbol and string");

   a_end_returns_idle: assert property (@(posedge clock) disable iff (reset)
      take && cls == CLS_NUL |=> mode_ff == MODE_IDLE)
      else $error("end byte did not return the scanner to idle");

   a_error_mode_silent: assert property (@(posedge clock) disable iff (reset)
      take && mode_ff == MODE_ERROR && cls != CLS_NUL |-> !wr.push0)
      else $error("token produced while in error mode");

endmodule

`default_nettype wire

// ===== src/lts_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// lts_rsp_fifo
// Result queue: takes up to two tokens per cycle from the scan engine and
// hands them out one at a time, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none

module lts_rsp_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lts_pkg::rsp_write_type wr,
   output logic                        room,
   output lts_pkg::result_type         head,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop
);
   import lts_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);
   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   result_type       mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             pop_eff;

   assign rsp_empty = (cnt_ff == CNT_W'(0));
   assign head      = mem_ff[rd_ptr_ff];
   assign pop_eff   = rsp_pop && !rsp_empty;
   // room for two more beats
   assign room      = (cnt_ff <= CNT_W'(RSP_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(wr.push0) + PTR_W'(wr.push1);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop_eff);
   assign cnt_in    = cnt_ff + CNT_W'(wr.push0) + CNT_W'(wr.push1) - CNT_W'(pop_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push0) begin
         mem_ff[wr_ptr_ff] <= wr.r0;
      end
      if (wr.push1) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= wr.r1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wr.push0 || wr.push1) |-> room)
      else $error("result queue written without room");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      wr.push1 |-> wr.push0)
      else $error("second token pushed without a first");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RSP_DEPTH))
      else $error("result queue count out of range");

endmodule

`default_nettype wire

// ===== src/lisp_token_scanner.sv =====
// path: an accepted byte is registered in the front queue, then the scan engine
//   writes its tokens into the result queue, whose head drives the rsp ports
// throughput: one byte per cycle while tokens are popped as they appear; a
//   byte that closes a token and opens another yields two beats, so the pop
//   side sets the pace at one token per cycle
// reset: synchronous, clears scan mode, accumulator, length and both queues
// ----------------------------------------------------------------------------
// lisp_token_scanner
// Streaming s-expression lexer: one source byte in, parens, symbol and
// string bytes with their end markers, numbers, end and error tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

module lisp_token_scanner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [7:0]  req_char_code,
   input  wire logic        req_push,
   output logic             req_full,
   output logic [3:0]       rsp_kind,
   output logic [62:0]      rsp_number_value,
   output logic [7:0]       rsp_text_byte,
   output logic [15:0]      rsp_text_length,
   output logic             rsp_last,
   output logic             rsp_empty,
   input  wire logic        rsp_pop
);
   import lts_pkg::*;

   front_type     front;
   logic          take;
   logic          room;
   rsp_write_type wr;
   result_type    head;

   lts_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_char_code (req_char_code),
      .req_push      (req_push),
      .req_full      (req_full),
      .front         (front),
      .take          (take)
   );

   lts_back u_back (
      .clock (clock),
      .reset (reset),
      .front (front),
      .take  (take),
      .room  (room),
      .wr    (wr)
   );

   lts_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .room      (room),
      .head      (head),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   assign rsp_kind         = head.kind;
   assign rsp_number_value = head.number_value;
   assign rsp_text_byte    = head.text_byte;
   assign rsp_text_length  = head.text_length;
   assign rsp_last         = head.last;

endmodule

`default_nettype wire

// ===== dv/lisp_token_scanner_checker.sv =====
// ----------------------------------------------------------------------------
// lisp_token_scanner_checker
// Watches the byte and token channels of the scanner, predicts the token
// stream of every accepted byte and compares each popped beat with it.
// ----------------------------------------------------------------------------
module lisp_token_scanner_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_char_code,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [3:0]  rsp_kind,
   input  logic [62:0] rsp_number_value,
   input  logic [7:0]  rsp_text_byte,
   input  logic [15:0] rsp_text_length,
   input  logic        rsp_last,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   output int          mismatches,
   output int          tokens_pending,
   output int          tokens_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   import lts_pkg::*;

   localparam logic [62:0] VALUE_MAX  = '1;
   localparam logic [7:0]  NUL_BYTE   = 8'h00;
   localparam logic [7:0]  CR_BYTE    = 8'h0D;

   logic [2:0]  scan_mode;
   logic [62:0] value_acc;
   logic [15:0] length_count;
   result_type  pending_tokens[$];
   int          fail_count;
   int          checked_count;

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_upper(input logic [7:0] c);
      return c >= "A" && c <= "Z";
   endfunction

   function automatic void add_token(input logic [3:0] kind, input logic [62:0] value,
                                     input logic [7:0] text_char, input logic [15:0] length);
      result_type t;
      t.kind         = kind;
      t.number_value = value;
      t.text_byte    = text_char;
      t.text_length  = length;
      t.last         = 1'b0;
      pending_tokens.push_back(t);
   endfunction

   function automatic void bump_length();
      if (length_count != LENGTH_MAX) length_count = length_count + 16'd1;
   endfunction

   // a byte seen with no token open, also the tail of a delimiter
   function automatic void lex_idle(input logic [7:0] c);
      scan_mode = MODE_IDLE;
      if (c == NUL_BYTE) begin
         value_acc    = '0;
         length_count = '0;
         add_token(KIND_END, '0, '0, '0);
      end else if (c == "(") begin
         add_token(KIND_LPAREN, '0, '0, '0);
      end else if (c == ")") begin
         add_token(KIND_RPAREN, '0, '0, '0);
      end else if (is_upper(c)) begin
         scan_mode    = MODE_SYMBOL;
         length_count = 16'd1;
         add_token(KIND_SYMBYTE, '0, c, '0);
      end else if (is_digit(c)) begin
         scan_mode = MODE_NUMBER;
         value_acc = 63'(c - "0");
      end else if (c == "\"") begin
         scan_mode    = MODE_STRING;
         length_count = '0;
      end else if (c == ";") begin
         scan_mode = MODE_COMMENT;
      end else if (!(c == " " || c == CR_BYTE || c == "\n" || c == "\t")) begin
         scan_mode = MODE_ERROR;
         add_token(KIND_ERROR, '0, '0, '0);
      end
   endfunction

   function automatic void lex_byte(input logic [7:0] c);
      int          already;
      result_type  tail;
      logic [63:0] digit;
      already = pending_tokens.size();
      case (scan_mode)
         MODE_SYMBOL: begin
            if (is_upper(c) || is_digit(c)) begin
               bump_length();
               add_token(KIND_SYMBYTE, '0, c, '0);
            end else begin
               add_token(KIND_SYMEND, '0, '0, length_count);
               length_count = '0;
               lex_idle(c);
            end
         end
         MODE_NUMBER: begin
            if (is_digit(c)) begin
               digit = c - "0";
               if ({1'b0, value_acc} > ({1'b0, VALUE_MAX} - digit) / 64'd10)
                  value_acc = VALUE_MAX;
               else
                  value_acc = 63'({1'b0, value_acc} * 64'd10 + digit);
            end else begin
               add_token(KIND_NUMBER, value_acc, '0, '0);
               value_acc = '0;
               lex_idle(c);
            end
         end
         MODE_STRING: begin
            if (c == "\"") begin
               add_token(KIND_STREND, '0, '0, length_count);
               length_count = '0;
               scan_mode    = MODE_IDLE;
            end else if (c == NUL_BYTE) begin
               // unterminated string
               add_token(KIND_ERROR, '0, '0, '0);
               lex_idle(c);
            end else begin
               bump_length();
               add_token(KIND_STRBYTE, '0, c, '0);
            end
         end
         MODE_COMMENT: begin
            if (c == "\n") scan_mode = MODE_IDLE;
            else if (c == NUL_BYTE) lex_idle(c);
         end
         MODE_ERROR: begin
            if (c == NUL_BYTE) lex_idle(c);
         end
         default: lex_idle(c);
      endcase
      if (pending_tokens.size() > already) begin
         tail      = pending_tokens.pop_back();
         tail.last = 1'b1;
         pending_tokens.push_back(tail);
      end
   endfunction

   function automatic void report(input string field, input logic [63:0] expected_value,
                                  input logic [63:0] actual_value);
      fail_count++;
      $display("%0t: %s expected %0h actual %0h", $time, field, expected_value,
               actual_value);
   endfunction

   function automatic void check_beat();
      result_type want;
      if (pending_tokens.size() == 0) begin
         report("unexpected beat, kind", 64'hFFFF_FFFF_FFFF_FFFF, 64'(rsp_kind));
         return;
      end
      want = pending_tokens.pop_front();
      checked_count++;
      if (rsp_kind != want.kind) report("kind", 64'(want.kind), 64'(rsp_kind));
      if (rsp_number_value != want.number_value)
         report("number_value", 64'(want.number_value), 64'(rsp_number_value));
      if (rsp_text_byte != want.text_byte)
         report("text_byte", 64'(want.text_byte), 64'(rsp_text_byte));
      if (rsp_text_length != want.text_length)
         report("text_length", 64'(want.text_length), 64'(rsp_text_length));
      if (rsp_last != want.last) report("last", 64'(want.last), 64'(rsp_last));
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         scan_mode    = MODE_IDLE;
         value_acc    = '0;
         length_count = '0;
         pending_tokens.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         // the newest byte cannot have a beat out yet, so pops go first
         if (rsp_pop && !rsp_empty) check_beat();
         if (req_push && !req_full) lex_byte(req_char_code);
      end
      mismatches     <= fail_count;
      tokens_pending <= pending_tokens.size();
      tokens_checked <= checked_count;
   end

endmodule

// ===== dv/lisp_token_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// lisp_token_scanner_tb
// Feeds the scanner directed texts, saturating numbers and random
// s-expression texts with random gaps on both sides; the checker beside the
// block predicts and compares every token beat.
// ----------------------------------------------------------------------------
module lisp_token_scanner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] END_BYTE    = 8'h00;
   localparam logic [7:0] CR_BYTE     = 8'h0D;
   localparam int         ITEM_TARGET = 1600;
   localparam int         CYCLE_LIMIT = 2000000;
   localparam string      PUNCT       = "#!$%&'*+,-./:<=>?@[\\]^_`{|}~";

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [3:0]  rsp_kind;
   logic [62:0] rsp_number_value;
   logic [7:0]  rsp_text_byte;
   logic [15:0] rsp_text_length;
   logic        rsp_last;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;

   int mismatches;
   int tokens_pending;
   int tokens_checked;
   int cycle_count = 0;
   int bytes_sent = 0;
   int texts_sent = 0;
   bit send_steady = 1'b0;
   bit pop_steady = 1'b0;

   always #5 clock = ~clock;

   lisp_token_scanner DUT (
      .clock            (clock),
      .reset            (reset),
      .req_char_code    (req_char_code),
      .req_push         (req_push),
      .req_full         (req_full),
      .rsp_kind         (rsp_kind),
      .rsp_number_value (rsp_number_value),
      .rsp_text_byte    (rsp_text_byte),
      .rsp_text_length  (rsp_text_length),
      .rsp_last         (rsp_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop)
   );

   lisp_token_scanner_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_char_code    (req_char_code),
      .req_push         (req_push),
      .req_full         (req_full),
      .rsp_kind         (rsp_kind),
      .rsp_number_value (rsp_number_value),
      .rsp_text_byte    (rsp_text_byte),
      .rsp_text_length  (rsp_text_length),
      .rsp_last         (rsp_last),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .mismatches       (mismatches),
      .tokens_pending   (tokens_pending),
      .tokens_checked   (tokens_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d tokens outstanding", cycle_count,
                  tokens_pending);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // token side: random stall before each beat unless in a steady stretch
   initial begin
      int stall;
      forever begin
         stall = pop_steady ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
      end
   end

   task automatic send_byte(input logic [7:0] c);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (tokens_pending != 0) @(posedge clock);
   endtask

   task automatic send_blank();
      int n;
      int pick;
      n = $urandom_range(1, 3);
      repeat (n) begin
         pick = $urandom_range(0, 3);
         case (pick)
            0: send_byte(" ");
            1: send_byte("\n");
            2: send_byte("\t");
            default: send_byte(CR_BYTE);
         endcase
      end
   endtask

   task automatic send_symbol(input int extra);
      send_byte(8'($urandom_range("A", "Z")));
      repeat (extra) begin
         if ($urandom_range(0, 9) < 7) send_byte(8'($urandom_range("A", "Z")));
         else send_byte(8'($urandom_range("0", "9")));
      end
   endtask

   task automatic send_number();
      int digits;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) digits = $urandom_range(1, 4);
      else if (pick < 9) digits = $urandom_range(5, 18);
      else digits = $urandom_range(19, 22);
      repeat (digits) send_byte(8'($urandom_range("0", "9")));
   endtask

   task automatic send_string(input bit closed, input int length);
      logic [7:0] c;
      send_byte("\"");
      repeat (length) begin
         do c = 8'($urandom_range(1, 255)); while (c == "\"");
         send_byte(c);
      end
      if (closed) send_byte("\"");
   endtask

   task automatic send_comment();
      int n;
      logic [7:0] c;
      n = $urandom_range(0, 8);
      send_byte(";");
      repeat (n) begin
         do c = 8'($urandom_range(1, 255)); while (c == "\n");
         send_byte(c);
      end
      send_byte("\n");
   endtask

   // illegal byte, some bytes that error mode swallows, then the end byte
   task automatic send_broken_text();
      int pick;
      int junk;
      pick = $urandom_range(0, 2);
      case (pick)
         0: send_byte(8'($urandom_range("a", "z")));
         1: send_byte(8'($urandom_range(128, 255)));
         default: send_byte(PUNCT[$urandom_range(0, PUNCT.len() - 1)]);
      endcase
      junk = $urandom_range(0, 6);
      repeat (junk) begin
         send_byte(8'($urandom_range(1, 255)));
      end
      send_byte(END_BYTE);
   endtask

   task automatic random_text();
      int tokens;
      int pick;
      tokens = $urandom_range(1, 12);
      for (int t = 0; t < tokens; t++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) send_byte("(");
         else if (pick < 24) send_byte(")");
         else if (pick < 44) send_symbol($urandom_range(0, 6));
         else if (pick < 62) send_number();
         else if (pick < 74) send_string(1'b1, $urandom_range(0, 10));
         else if (pick < 80) send_comment();
         else if (pick < 86) send_blank();
         else if (pick < 90) begin
            send_broken_text();
            return;
         end else if (pick < 93) begin
            send_string(1'b0, $urandom_range(0, 6));
            send_byte(END_BYTE);
            return;
         end else send_byte(8'($urandom_range(1, 255)));
         // no separator half the time, so tokens end on each other
         if ($urandom_range(0, 1)) send_blank();
      end
      send_byte(END_BYTE);
   endtask

   initial begin
      int pick;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed texts
      send_byte(END_BYTE);
      send_text("(A ZZ9 0)");
      send_byte(END_BYTE);
      send_text("(B1(12)7Q \"hi\" \"\"; note\n\t");
      send_byte(CR_BYTE);
      send_text("9223372036854775807 9223372036854775808 99999999999999999999)");
      send_byte(END_BYTE);
      send_text("#X(");
      send_byte(END_BYTE);
      send_text("\"ab");
      send_byte(END_BYTE);
      send_text("; tail");
      send_byte(END_BYTE);
      send_byte(8'hFF);
      send_byte(END_BYTE);
      send_text("A");
      send_byte(END_BYTE);
      send_text("5");
      send_byte(END_BYTE);
      wait_drained();

      // random texts, with steady stretches and the odd full drain
      while (bytes_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         send_steady = pick < 3;
         pop_steady  = pick < 2 || pick == 3;
         random_text();
         texts_sent++;
         if (texts_sent % 20 == 10) wait_drained();
      end
      send_steady = 1'b0;
      pop_steady  = 1'b0;

      wait_drained();
      repeat (10) @(posedge clock);
      $display("sent %0d bytes (%0d random texts), checked %0d token beats", bytes_sent,
               texts_sent, tokens_checked);
      $display("covered delimiters, saturating numbers, errors and end in every scan mode");
      if (mismatches == 0 && tokens_pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
